FILE: hdl/xor_residual_rle_encoder_assert.svh
// ----------------------------------------------------------------------------
// xor_residual_rle_encoder_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef XOR_RESIDUAL_RLE_ENCODER_ASSERT_SVH
`define XOR_RESIDUAL_RLE_ENCODER_ASSERT_SVH

// same-cycle implication, gated by reset
`define XRE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define XRE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/xre_pkg.sv
// ----------------------------------------------------------------------------
// xre_pkg
// types and constants of the xor residual run-length encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xre_pkg;

  localparam logic [7:0] RunMax = 8'd255;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // what follows the optional flush pair of a command
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_RAW,
    TAIL_PAIR
  } tail_e;

  // beat position within a command
  typedef enum logic [1:0] {
    STEP_FLUSH_CNT,
    STEP_FLUSH_VAL,
    STEP_TAIL_A,
    STEP_TAIL_B
  } step_e;

  // one command from the front to the back
  typedef struct packed {
    logic       flush;
    logic [7:0] flush_count;
    logic [7:0] flush_value;
    tail_e      tail;
    logic [7:0] tail_a;
    logic [7:0] tail_b;
    logic       tail_last;
  } cmd_t;

endpackage

FILE: hdl/xre_front.sv
// ----------------------------------------------------------------------------
// xre_front
// takes input beats, forms the residual, tracks the run, issues commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xre_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          encode_mode_we_i,
  input  logic          encode_mode_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    original_byte_i,
  input  logic [7:0]    rebuilt_byte_i,
  input  logic          last_in_i,
  output logic          cmd_valid_o,
  output xre_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);

  logic       mode_q;
  logic [7:0] run_value_q, run_value_d;
  logic [7:0] run_count_q, run_count_d;
  logic       run_open_q, run_open_d;
  logic [7:0] residual;
  logic       accept;
  logic       join_run;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i & cmd_ready_i;
  assign residual   = original_byte_i ^ rebuilt_byte_i;
  assign join_run   = run_open_q && (residual == run_value_q) && (run_count_q != xre_pkg::RunMax);

  always_comb begin
    cmd_o       = '0;
    cmd_o.tail  = xre_pkg::TAIL_NONE;
    run_value_d = run_value_q;
    run_count_d = run_count_q;
    run_open_d  = run_open_q;
    if (!mode_q) begin
      cmd_o.flush       = run_open_q;
      cmd_o.flush_count = run_count_q;
      cmd_o.flush_value = run_value_q;
      cmd_o.tail        = xre_pkg::TAIL_RAW;
      cmd_o.tail_a      = residual;
      cmd_o.tail_b      = residual;
      cmd_o.tail_last   = last_in_i;
      run_open_d        = 1'b0;
      run_count_d       = '0;
      run_value_d       = '0;
    end else begin
      if (join_run) begin
        run_count_d = run_count_q + 8'd1;
      end else begin
        cmd_o.flush       = run_open_q;
        cmd_o.flush_count = run_count_q;
        cmd_o.flush_value = run_value_q;
        run_open_d        = 1'b1;
        run_value_d       = residual;
        run_count_d       = 8'd1;
      end
      if (last_in_i) begin
        // close the run that holds this byte
        cmd_o.tail      = xre_pkg::TAIL_PAIR;
        cmd_o.tail_a    = run_count_d;
        cmd_o.tail_b    = run_value_d;
        cmd_o.tail_last = 1'b1;
        run_open_d      = 1'b0;
        run_count_d     = '0;
        run_value_d     = '0;
      end
    end
  end

  assign cmd_valid_o = accept & (cmd_o.flush | (cmd_o.tail != xre_pkg::TAIL_NONE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      run_value_q <= '0;
      run_count_q <= '0;
      run_open_q  <= 1'b0;
    end else begin
      if (encode_mode_we_i) begin
        mode_q <= encode_mode_i;
      end
      if (accept) begin
        run_value_q <= run_value_d;
        run_count_q <= run_count_d;
        run_open_q  <= run_open_d;
      end
    end
  end

endmodule

FILE: hdl/xre_queue.sv
// ----------------------------------------------------------------------------
// xre_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xre_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xre_pkg::cmd_t push_cmd_i,
  output logic          space_o,
  output logic          head_valid_o,
  output xre_pkg::cmd_t head_cmd_o,
  input  logic          pop_i
);

  xre_pkg::cmd_t                     mem_q [xre_pkg::QueueDepth];
  logic [xre_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [xre_pkg::QueueCntW-1:0]     count_q;
  logic                              do_push, do_pop;

  assign space_o      = (count_q != xre_pkg::QueueCntW'(xre_pkg::QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & space_o;
  assign do_pop       = pop_i & head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == xre_pkg::QueuePtrW'(xre_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == xre_pkg::QueuePtrW'(xre_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/xre_back.sv
// ----------------------------------------------------------------------------
// xre_back
// walks each command beat by beat into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xre_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  xre_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          last_out_o
);

  xre_pkg::step_e step_q, step_d, cur_step;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q, beat_byte;
  logic           last_out_q, beat_last;
  logic           load;
  logic           done;

  assign load = cmd_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    cur_step = step_q;
    if (step_q == xre_pkg::STEP_FLUSH_CNT && !cmd_i.flush) begin
      cur_step = xre_pkg::STEP_TAIL_A;
    end
    beat_byte = cmd_i.tail_b;
    beat_last = cmd_i.tail_last;
    done      = 1'b1;
    step_d    = step_q;
    unique case (cur_step)
      xre_pkg::STEP_FLUSH_CNT: begin
        beat_byte = cmd_i.flush_count;
        beat_last = 1'b0;
        done      = 1'b0;
        if (load) step_d = xre_pkg::STEP_FLUSH_VAL;
      end
      xre_pkg::STEP_FLUSH_VAL: begin
        beat_byte = cmd_i.flush_value;
        beat_last = 1'b0;
        done      = (cmd_i.tail == xre_pkg::TAIL_NONE);
        if (load) step_d = done ? xre_pkg::STEP_FLUSH_CNT : xre_pkg::STEP_TAIL_A;
      end
      xre_pkg::STEP_TAIL_A: begin
        beat_byte = cmd_i.tail_a;
        done      = (cmd_i.tail != xre_pkg::TAIL_PAIR);
        beat_last = done & cmd_i.tail_last;
        if (load) step_d = done ? xre_pkg::STEP_FLUSH_CNT : xre_pkg::STEP_TAIL_B;
      end
      xre_pkg::STEP_TAIL_B: begin
        beat_byte = cmd_i.tail_b;
        beat_last = cmd_i.tail_last;
        done      = 1'b1;
        if (load) step_d = xre_pkg::STEP_FLUSH_CNT;
      end
      default: begin
        step_d = xre_pkg::STEP_FLUSH_CNT;
      end
    endcase
  end

  assign cmd_pop_o   = load & done;
  assign out_valid_d = load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= xre_pkg::STEP_FLUSH_CNT;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= beat_byte;
      last_out_q <= beat_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_out_o  = last_out_q;

endmodule

FILE: hdl/xor_residual_rle_encoder.sv
// ----------------------------------------------------------------------------
// xor_residual_rle_encoder
// xor residual byte encoder, raw or run-length count/value pairs
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o with original_byte_i, rebuilt_byte_i
//   and last_in_i; one beat is one byte position of the block
//   output channel: out_valid_o / out_ready_i with out_byte_o and last_out_o
//   encode_mode_we_i / encode_mode_i write the mode (0 raw, 1 run-length),
//   only while the block is idle; it applies from the next input beat
//   an accepted item passes through the queue and then the output register
//   throughput: one input beat per cycle while the queue has room; the output
//   side sends one byte per cycle while out_ready_i is high, so closing a run
//   (count then value) takes two output beats and run-length data with short
//   runs is limited by the single byte-wide output register
//   reset: mode goes to run-length, no open run, queue and output empty
//   a stalled receiver holds the output register, the queue (two commands)
//   fills and then in_ready_o drops; nothing is lost
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_residual_rle_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       encode_mode_we_i,
  input  logic       encode_mode_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] original_byte_i,
  input  logic [7:0] rebuilt_byte_i,
  input  logic       last_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_out_o
);

  // front to queue
  logic          push;
  xre_pkg::cmd_t push_cmd;
  logic          space;

  // queue to back
  logic          head_valid;
  xre_pkg::cmd_t head_cmd;
  logic          pop;

  // front: residual, run tracking, one command per accepted beat at most
  xre_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .encode_mode_we_i (encode_mode_we_i),
    .encode_mode_i    (encode_mode_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .original_byte_i  (original_byte_i),
    .rebuilt_byte_i   (rebuilt_byte_i),
    .last_in_i        (last_in_i),
    .cmd_valid_o      (push),
    .cmd_o            (push_cmd),
    .cmd_ready_i      (space)
  );

  // decouples the front from output stalls
  xre_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .space_o      (space),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  // back: up to four output beats per command
  xre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_out_o  (last_out_o)
  );

endmodule

FILE: hdl/xre_checker.sv
// ----------------------------------------------------------------------------
// xre_checker
// port-level checks of the xor residual run-length encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xor_residual_rle_encoder_assert.svh"

module xre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       encode_mode_we_i,
  input logic       encode_mode_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] original_byte_i,
  input logic [7:0] rebuilt_byte_i,
  input logic       last_in_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_out_o
);

  // a stalled output beat holds its payload
  `XRE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(last_out_o), "output beat changed while stalled")

  // an empty output register means the queue cannot be full
  `XRE_ASSERT_NOW(a_idle_ready, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output")

  // leaving reset: nothing to send, room to take
  `XRE_ASSERT_NOW(a_reset_state, clk_i, rst_ni, $rose(rst_ni), !out_valid_o && in_ready_o, "bad state after reset")

endmodule

bind xor_residual_rle_encoder xre_checker u_xre_checker (.*);

FILE: bench/xor_residual_rle_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_residual_rle_encoder_test
// self-checking bench for the xor residual run-length encoder
// ----------------------------------------------------------------------------
// byte pairs are queued by the phase sequence below and offered in bursts by
// a clocked driver; every accepted beat is run through a behavioural model of
// the encoder that queues the output beats it should cause. a clocked monitor
// stalls the output side on its own pattern and compares every output beat
// with the oldest queued one. the mode register is only written while the
// block is drained; phases cover raw and run-length mode, runs split at the
// count cap, open runs flushed by a switch to raw mode, and a long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module xor_residual_rle_encoder_test;

  localparam logic ModeRaw = 1'b0;
  localparam logic ModeRle = 1'b1;
  localparam logic [7:0] CountCap = 8'd255;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 12;

  // how the receiver paces out_ready_i
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } ready_style_e;

  // one input beat: a byte of original data and its rebuilt counterpart
  typedef struct packed {
    logic [7:0] original;
    logic [7:0] rebuilt;
    logic       last;
  } byte_pair_t;

  // one output beat as the encoder should send it
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } coded_beat_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic       encode_mode_we_i = 1'b0;
  logic       encode_mode_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] original_byte_i = 8'h00;
  logic [7:0] rebuilt_byte_i = 8'h00;
  logic       last_in_i = 1'b0;
  logic       out_ready_i = 1'b0;

  // block outputs
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_out_o;

  // pairs waiting to be offered, and beats waiting to come out
  byte_pair_t  byte_pairs_q[$];
  coded_beat_t coded_bytes_q[$];

  // model state: mode register and the open run
  logic       mode_shadow = ModeRle;
  logic [7:0] run_byte = 8'h00;
  logic [7:0] run_len = 8'h00;
  logic       run_live = 1'b0;

  // driver pacing
  int   burst_left = 0;
  int   gap_left = 0;
  logic steady_send = 1'b0;
  logic offer_live = 1'b0;

  // receiver pacing
  ready_style_e stall_style = STALL_NONE;
  logic hold_wanted = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   pattern_pos = 0;

  // tallies
  int mismatches = 0;
  int items_sent = 0;
  int beats_checked = 0;
  int capped_runs = 0;
  int raw_flushes = 0;

  always #5 clk_i = ~clk_i;

  xor_residual_rle_encoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .encode_mode_we_i (encode_mode_we_i),
    .encode_mode_i    (encode_mode_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .original_byte_i  (original_byte_i),
    .rebuilt_byte_i   (rebuilt_byte_i),
    .last_in_i        (last_in_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_out_o       (last_out_o)
  );

  // ---------------------------------------------------------------------------
  // behavioural model
  // ---------------------------------------------------------------------------

  // close the open run: count beat, then value beat
  function automatic void close_run(input logic is_last);
    coded_beat_t beat;
    beat.value = run_len;
    beat.last  = 1'b0;
    coded_bytes_q = {coded_bytes_q, beat};
    beat.value = run_byte;
    beat.last  = is_last;
    coded_bytes_q = {coded_bytes_q, beat};
    run_live = 1'b0;
    run_len  = 8'h00;
    run_byte = 8'h00;
  endfunction

  // work out the beats caused by one accepted byte pair
  function automatic void encode_residual(input logic [7:0] original,
                                          input logic [7:0] rebuilt,
                                          input logic is_last);
    logic [7:0]  residual;
    coded_beat_t beat;
    residual = original ^ rebuilt;
    if (mode_shadow == ModeRaw) begin
      // a run left open from run-length mode goes out first
      if (run_live) begin
        close_run(1'b0);
        raw_flushes++;
      end
      beat.value = residual;
      beat.last  = is_last;
      coded_bytes_q = {coded_bytes_q, beat};
    end else begin
      if (run_live && residual == run_byte && run_len != CountCap) begin
        run_len = run_len + 8'd1;
      end else begin
        if (run_live) begin
          if (residual == run_byte) capped_runs++;
          close_run(1'b0);
        end
        run_live = 1'b1;
        run_byte = residual;
        run_len  = 8'd1;
      end
      // end of block flushes whatever run holds this byte
      if (is_last) close_run(1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued pairs in bursts with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_pairs
    logic       busy;
    byte_pair_t pair;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      offer_live = 1'b0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        encode_residual(original_byte_i, rebuilt_byte_i, last_in_i);
        items_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0 && !steady_send) begin
          gap_left--;
        end else if (byte_pairs_q.size() > 0) begin
          pair = byte_pairs_q.pop_front();
          original_byte_i <= pair.original;
          rebuilt_byte_i  <= pair.rebuilt;
          last_in_i       <= pair.last;
          busy = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // new burst; some bursts follow on with no gap at all
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
      offer_live = busy;
      in_valid_i <= busy;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: paces out_ready_i and checks every output beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beats
    coded_beat_t want;
    logic        ready_next;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (coded_bytes_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual byte %02h last %0b",
                   $time, out_byte_o, last_out_o);
          mismatches++;
        end else begin
          want = coded_bytes_q.pop_front();
          beats_checked++;
          if (out_byte_o !== want.value) begin
            $display("%0t: out_byte wrong: expected %02h, actual %02h",
                     $time, want.value, out_byte_o);
            mismatches++;
          end
          if (last_out_o !== want.last) begin
            $display("%0t: last_out wrong: expected %0b, actual %0b",
                     $time, want.last, last_out_o);
            mismatches++;
          end
        end
      end

      // one long hold-off on request, counted here
      if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end

      pattern_pos++;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (stall_style)
          STALL_RANDOM:  ready_next = ($urandom_range(0, 99) >= 35);
          STALL_PATTERN: ready_next = (pattern_pos % 5 != 0) && (pattern_pos % 7 != 3);
          default:       ready_next = 1'b1;
        endcase
      end
      out_ready_i <= ready_next;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic offer_pair(input logic [7:0] original, input logic [7:0] rebuilt,
                            input logic is_last);
    byte_pair_t pair;
    pair.original = original;
    pair.rebuilt  = rebuilt;
    pair.last     = is_last;
    byte_pairs_q = {byte_pairs_q, pair};
  endtask

  // mode writes happen only with the block drained
  task automatic write_mode(input logic mode);
    @(posedge clk_i);
    encode_mode_we_i <= 1'b1;
    encode_mode_i    <= mode;
    mode_shadow = mode;
    @(posedge clk_i);
    encode_mode_we_i <= 1'b0;
  endtask

  // wait until every pair is taken and every beat has come out, then a margin
  // for pairs that cause no beat
  task automatic settle();
    while (byte_pairs_q.size() != 0 || offer_live || coded_bytes_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // blocks made of runs with random content, a few stray bytes breaking runs;
  // open_tail leaves the last block without its end marker
  task automatic queue_blocks(input int count, input logic open_tail);
    int         queued;
    int         block_len;
    int         run_count;
    int         k;
    logic [7:0] value;
    logic [7:0] residual;
    logic [7:0] original;
    logic       mark;
    queued = 0;
    while (queued < count) begin
      block_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                              : $urandom_range(1, 16);
      if (queued + block_len > count) block_len = count - queued;
      k = 0;
      while (k < block_len) begin
        case ($urandom_range(0, 9))
          0:       value = 8'h00;
          1:       value = 8'hFF;
          default: value = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: run_count = $urandom_range(1, 2);
          4, 5, 6, 7: run_count = $urandom_range(3, 8);
          default:    run_count = $urandom_range(9, 24);
        endcase
        while (run_count > 0 && k < block_len) begin
          residual = ($urandom_range(0, 19) == 0) ? 8'($urandom) : value;
          original = 8'($urandom);
          mark = (k == block_len - 1) && !(open_tail && queued + k == count - 1);
          offer_pair(original, original ^ residual, mark);
          run_count--;
          k++;
        end
      end
      queued += block_len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // phase sequence
  // ---------------------------------------------------------------------------
  initial begin : run_phases
    int         k;
    int         span;
    logic [7:0] original;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset mode is run-length
    stall_style = STALL_RANDOM;
    offer_pair(8'h00, 8'h00, 1'b1);          // single-byte block, residual zero
    offer_pair(8'hFF, 8'h00, 1'b0);          // run of four all-ones residuals
    offer_pair(8'h00, 8'hFF, 1'b0);
    offer_pair(8'hAA, 8'h55, 1'b0);
    offer_pair(8'h0F, 8'hF0, 1'b1);
    offer_pair(8'hA5, 8'h00, 1'b0);          // run closed by a new value at the end
    offer_pair(8'h00, 8'hA5, 1'b0);
    offer_pair(8'h5A, 8'h00, 1'b1);
    offer_pair(8'h81, 8'h42, 1'b0);          // different every byte
    offer_pair(8'h7E, 8'h01, 1'b0);
    offer_pair(8'h01, 8'h80, 1'b1);
    offer_pair(8'h3C, 8'h00, 1'b0);          // run left open across the mode switch
    offer_pair(8'hC3, 8'hFF, 1'b0);
    settle();

    // raw mode with a run still open: it is flushed before the first raw byte
    write_mode(ModeRaw);
    stall_style = STALL_PATTERN;
    offer_pair(8'hFF, 8'hFF, 1'b0);
    offer_pair(8'h80, 8'h7F, 1'b1);
    offer_pair(8'h01, 8'h00, 1'b0);
    offer_pair(8'hFE, 8'h00, 1'b1);
    settle();

    // back to run-length, run opened after raw bytes
    write_mode(ModeRle);
    stall_style = STALL_NONE;
    offer_pair(8'h11, 8'h00, 1'b0);
    offer_pair(8'h00, 8'h11, 1'b0);
    offer_pair(8'h22, 8'h33, 1'b0);
    offer_pair(8'h44, 8'h55, 1'b1);
    settle();

    // random blocks, run left open at the end
    stall_style = STALL_RANDOM;
    queue_blocks(8, 1'b1);
    settle();

    write_mode(ModeRaw);
    stall_style = STALL_PATTERN;
    queue_blocks(6, 1'b0);
    settle();

    // runs past the count cap, sent with no gaps
    write_mode(ModeRle);
    stall_style = STALL_NONE;
    steady_send = 1'b1;
    span = $urandom_range(256, 262);
    for (k = 0; k < span; k++) begin
      original = 8'($urandom);
      offer_pair(original, original ^ 8'h96, k == span - 1);
    end
    settle();

    // receiver holds off while the sender keeps offering
    stall_style = STALL_RANDOM;
    hold_wanted = 1'b1;
    queue_blocks(12, 1'b0);
    settle();
    steady_send = 1'b0;

    write_mode(ModeRaw);
    queue_blocks(6, 1'b0);
    settle();

    write_mode(ModeRle);
    stall_style = STALL_PATTERN;
    queue_blocks(6, 1'b1);
    settle();

    // raw switch flushes the open run again, then close the stream out
    write_mode(ModeRaw);
    stall_style = STALL_RANDOM;
    queue_blocks(4, 1'b0);
    settle();

    write_mode(ModeRle);
    stall_style = STALL_NONE;
    queue_blocks(4, 1'b0);
    settle();

    $display("run covered %0d input beats and %0d output beats in raw and run-length mode",
             items_sent, beats_checked);
    $display("%0d runs split at the count cap, %0d open runs flushed by a switch to raw",
             capped_runs, raw_flushes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard limit on the run
  initial begin : run_limit
    #5000000;
    $display("%0t: run timed out with %0d beats still expected", $time, coded_bytes_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/xre_pkg.sv
hdl/xre_front.sv
hdl/xre_queue.sv
hdl/xre_back.sv
hdl/xor_residual_rle_encoder.sv
hdl/xre_checker.sv
bench/xor_residual_rle_encoder_test.sv
